@@ sv/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo pulse threshold switch package
// Shared item types, register indexes and timing constants.
// ----------------------------------------------------------------------------
package sps_pkg;

   // Pulse width limits, in 16 us counts
   localparam logic [7:0] PW_TOO_LONG    = 8'd168;
   localparam logic [7:0] PW_SPIKE       = 8'd20;
   localparam logic [7:0] PW_DEFAULT_MID = 8'd94;

   // Setup capture
   localparam logic signed [7:0] SETUP_MIN_DIFF = 8'sd4;
   localparam logic [2:0] DEBOUNCE_LIMIT   = 3'd5;
   localparam logic [4:0] ERROR_HOLD_STEPS = 5'd20;

   // LED sequencer
   localparam logic [2:0] BLINK_DIV_LIMIT = 3'd4;
   localparam logic [3:0] STABLE_MAX      = 4'd15;

   // Register defaults
   localparam logic [3:0]  STABILITY_COUNT_RESET = 4'd3;
   localparam logic [15:0] NO_SIGNAL_TICKS_RESET = 16'd2500;
   localparam logic [3:0]  HALF_HYST_RESET       = 4'd2;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_INITIAL_MIDPOINT = 3'd0,
      CSR_INITIAL_RELAY    = 3'd1,
      CSR_STABILITY_COUNT  = 3'd2,
      CSR_NO_SIGNAL_TICKS  = 3'd3,
      CSR_HALF_HYSTERESIS  = 3'd4
   } csr_index_type;

   // One input item
   typedef struct packed {
      logic       mode;
      logic [7:0] pulse_width;
      logic       setup_link;
   } item_type;

   // One result item
   typedef struct packed {
      logic       relay_on;
      logic       led_on;
      logic       no_signal;
      logic       setup_active;
      logic       error_flag;
      logic [7:0] midpoint;
      logic       store_midpoint;
      logic       store_relay;
   } result_type;

   // Stored midpoint outside the usable window falls back to the default
   function automatic logic [7:0] valid_mid(input logic [7:0] m);
      valid_mid = (m >= PW_TOO_LONG || m <= PW_SPIKE) ? PW_DEFAULT_MID : m;
   endfunction

endpackage

@@ sv/sps_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the core step consumes it.
// ----------------------------------------------------------------------------
module sps_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sps_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output sps_pkg::item_type item
);

   logic              valid_ff, valid_in;
   sps_pkg::item_type item_ff;

   // Free when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/sps_core.sv @@
// ----------------------------------------------------------------------------
// Switch core
// Control state, configuration registers and the per-item step logic.
// ----------------------------------------------------------------------------
module sps_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                step_en,
   input  sps_pkg::item_type   item,
   output sps_pkg::result_type result
);

   // Configuration
   logic [3:0]  stability_count_ff;
   logic [15:0] no_signal_ticks_ff;
   logic [3:0]  half_hyst_ff;

   // State
   logic       relay_ff, relay_in;
   logic [7:0] mid_ff, mid_in;
   logic [3:0] stable_ff, stable_in;
   logic [15:0] idle_ff, idle_in;
   logic       setup_on_ff, setup_on_in;
   logic [2:0] debounce_ff, debounce_in;
   logic [7:0] captured_ff, captured_in;
   logic       error_on_ff, error_on_in;
   logic [4:0] error_hold_ff, error_hold_in;
   logic [2:0] divider_ff, divider_in;
   logic [3:0] beat_ff, beat_in;
   logic       led_ff, led_in;
   logic       nosig_ff, nosig_in;

   // Step intermediates
   logic       strobe_mid, strobe_relay;
   logic       do_led, led_nosig, setup_en;
   logic [3:0] stable_inc;
   logic [15:0] idle_inc;
   logic [8:0] pw_plus_hyst, mid_plus_hyst;
   logic       want_relay;
   logic [4:0] beat_next;
   logic signed [7:0] setup_diff;

   assign stable_inc    = (stable_ff == sps_pkg::STABLE_MAX) ? stable_ff : stable_ff + 4'd1;
   assign idle_inc      = idle_ff + 16'd1;
   assign pw_plus_hyst  = {1'b0, item.pulse_width} + {5'b0, half_hyst_ff};
   assign mid_plus_hyst = {1'b0, mid_ff} + {5'b0, half_hyst_ff};
   // pw > mid - hyst when on, pw > mid + hyst when off
   assign want_relay    = relay_ff ? (pw_plus_hyst > {1'b0, mid_ff})
                                   : ({1'b0, item.pulse_width} > mid_plus_hyst);
   assign beat_next     = {1'b0, beat_ff} + 5'd1;
   assign setup_diff    = $signed({1'b0, item.pulse_width[7:1]})
                          - $signed({1'b0, captured_ff[7:1]});

   // Next state for one item
   always_comb begin
      relay_in      = relay_ff;
      mid_in        = mid_ff;
      stable_in     = stable_ff;
      idle_in       = idle_ff;
      setup_on_in   = setup_on_ff;
      debounce_in   = debounce_ff;
      captured_in   = captured_ff;
      error_on_in   = error_on_ff;
      error_hold_in = error_hold_ff;
      divider_in    = divider_ff;
      beat_in       = beat_ff;
      led_in        = led_ff;
      nosig_in      = nosig_ff;
      strobe_mid    = 1'b0;
      strobe_relay  = 1'b0;
      do_led        = 1'b0;
      led_nosig     = 1'b0;
      setup_en      = 1'b0;

      // Pulse classification or idle tick
      if (step_en) begin
         if (!item.mode) begin
            if (item.pulse_width > sps_pkg::PW_TOO_LONG) begin
               stable_in = '0;
               do_led    = 1'b1;
               led_nosig = 1'b1;
            end else if (item.pulse_width < sps_pkg::PW_SPIKE) begin
               stable_in = '0;
               idle_in   = '0;
            end else begin
               stable_in = stable_inc;
               idle_in   = '0;
               if (stable_inc >= stability_count_ff) begin
                  if (want_relay != relay_ff) begin
                     relay_in     = want_relay;
                     strobe_relay = 1'b1;
                  end
                  do_led   = 1'b1;
                  setup_en = 1'b1;
               end
            end
         end else begin
            idle_in = idle_inc;
            if (idle_inc > no_signal_ticks_ff) begin
               do_led    = 1'b1;
               led_nosig = 1'b1;
               idle_in   = '0;
            end
         end
      end

      // LED sequencer: one beat every fifth LED step
      if (do_led) begin
         nosig_in = led_nosig;
         if (divider_ff == sps_pkg::BLINK_DIV_LIMIT) begin
            divider_in = '0;
            beat_in    = beat_next[3:0];
            if (beat_next == 5'd1) begin
               led_in = 1'b1;
            end else if (beat_next == 5'd4) begin
               led_in = relay_in | setup_on_ff | error_on_ff;
            end else if (beat_next <= 5'd9) begin
               led_in = setup_on_ff | error_on_ff;
            end else if (beat_next[4] == 1'b0) begin
               led_in = error_on_ff;
            end else begin
               led_in = 1'b0;
            end
         end else begin
            divider_in = divider_ff + 3'd1;
         end
      end

      // Setup strap capture and midpoint learning
      if (setup_en) begin
         if (error_hold_ff != 5'd0) begin
            error_hold_in = error_hold_ff - 5'd1;
         end else begin
            error_on_in = 1'b0;
         end
         if (item.setup_link) begin
            if (debounce_ff < sps_pkg::DEBOUNCE_LIMIT) begin
               debounce_in = debounce_ff + 3'd1;
            end else if (!setup_on_ff) begin
               captured_in = item.pulse_width;
               setup_on_in = 1'b1;
            end
         end else begin
            if (setup_on_ff) begin
               if (setup_diff <= sps_pkg::SETUP_MIN_DIFF &&
                   setup_diff >= -sps_pkg::SETUP_MIN_DIFF) begin
                  error_hold_in = sps_pkg::ERROR_HOLD_STEPS;
                  error_on_in   = 1'b1;
               end else begin
                  mid_in     = captured_ff + setup_diff;
                  strobe_mid = 1'b1;
               end
            end
            setup_on_in = 1'b0;
            debounce_in = '0;
         end
      end

      // Start registers also load the live state
      if (csr_we) begin
         case (sps_pkg::csr_index_type'(csr_index))
            sps_pkg::CSR_INITIAL_MIDPOINT: begin
               mid_in = sps_pkg::valid_mid(csr_wdata[7:0]);
            end
            sps_pkg::CSR_INITIAL_RELAY: begin
               relay_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stability_count_ff <= sps_pkg::STABILITY_COUNT_RESET;
         no_signal_ticks_ff <= sps_pkg::NO_SIGNAL_TICKS_RESET;
         half_hyst_ff       <= sps_pkg::HALF_HYST_RESET;
      end else if (csr_we) begin
         case (sps_pkg::csr_index_type'(csr_index))
            sps_pkg::CSR_STABILITY_COUNT: stability_count_ff <= csr_wdata[3:0];
            sps_pkg::CSR_NO_SIGNAL_TICKS: no_signal_ticks_ff <= csr_wdata;
            sps_pkg::CSR_HALF_HYSTERESIS: half_hyst_ff       <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= 1'b0;
         mid_ff        <= sps_pkg::valid_mid(sps_pkg::PW_DEFAULT_MID);
         stable_ff     <= '0;
         idle_ff       <= '0;
         setup_on_ff   <= 1'b0;
         debounce_ff   <= '0;
         error_on_ff   <= 1'b0;
         error_hold_ff <= '0;
         divider_ff    <= '0;
         beat_ff       <= '0;
         led_ff        <= 1'b0;
         nosig_ff      <= 1'b0;
      end else begin
         relay_ff      <= relay_in;
         mid_ff        <= mid_in;
         stable_ff     <= stable_in;
         idle_ff       <= idle_in;
         setup_on_ff   <= setup_on_in;
         debounce_ff   <= debounce_in;
         error_on_ff   <= error_on_in;
         error_hold_ff <= error_hold_in;
         divider_ff    <= divider_in;
         beat_ff       <= beat_in;
         led_ff        <= led_in;
         nosig_ff      <= nosig_in;
      end
   end

   // Captured width is only read once setup is active
   always_ff @(posedge clock) begin
      captured_ff <= captured_in;
   end

   // Result of this step
   assign result.relay_on       = relay_in;
   assign result.led_on         = led_in;
   assign result.no_signal      = nosig_in;
   assign result.setup_active   = setup_on_in;
   assign result.error_flag     = error_on_in;
   assign result.midpoint       = mid_in;
   assign result.store_midpoint = strobe_mid;
   assign result.store_relay    = strobe_relay;

   // Checks
   a_mid_stored: assert property (@(posedge clock) disable iff (reset)
      step_en && result.store_midpoint |=> mid_ff == $past(result.midpoint))
      else $error("learned midpoint not stored");

   a_divider_range: assert property (@(posedge clock) disable iff (reset)
      divider_ff <= sps_pkg::BLINK_DIV_LIMIT)
      else $error("blink divider out of range");

   a_hold_needs_error: assert property (@(posedge clock) disable iff (reset)
      error_hold_ff != 5'd0 |-> error_on_ff)
      else $error("error hold running without error shown");

   a_setup_debounced: assert property (@(posedge clock) disable iff (reset)
      setup_on_ff |-> debounce_ff == sps_pkg::DEBOUNCE_LIMIT)
      else $error("setup active without full debounce");

endmodule

@@ sv/sps_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sps_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                advance,
   input  sps_pkg::result_type result,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sps_pkg::result_type rsp_result
);

   logic                valid_ff, valid_in;
   sps_pkg::result_type result_ff;

   // Step runs when an item waits and the register is free or draining
   assign advance  = item_valid && (!valid_ff || rsp_ready);
   assign valid_in = advance || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ sv/servo_pulse_threshold_switch.sv @@
// ----------------------------------------------------------------------------
// Servo pulse threshold switch
// Turns servo pulse widths into a relay drive with hysteresis and LED status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a completed pulse with its width (mode 0) or one
//   idle-low poll tick (mode 1), plus the setup strap level. rsp_* returns
//   exactly one result item per input item, in order: relay level, LED level,
//   status flags, current midpoint and one-item store strobes.
//   csr_* writes the five configuration registers; write only while idle.
//   Writing the start midpoint or relay loads the live value at once.
// Timing:
//   rsp_valid rises once the input register has taken the item and the step
//   logic has then loaded the result register; a held result that rsp_ready
//   does not take delays that load. One item per cycle is sustained while
//   rsp_ready stays high; the state loop closes within each item's step.
// Reset:
//   Synchronous; registers return to defaults, relay off, midpoint 94.
// Stall:
//   A held result keeps req_ready high while the input register is empty;
//   once both registers are full, req_ready drops until rsp_ready rises.
// ----------------------------------------------------------------------------
module servo_pulse_threshold_switch (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // Input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_pulse_width,
   input  logic        req_setup_link,
   // Result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_relay_on,
   output logic        rsp_led_on,
   output logic        rsp_no_signal,
   output logic        rsp_setup_active,
   output logic        rsp_error_flag,
   output logic [7:0]  rsp_midpoint,
   output logic        rsp_store_midpoint,
   output logic        rsp_store_relay
);

   sps_pkg::item_type   req_item;
   sps_pkg::item_type   item;
   sps_pkg::result_type result;
   sps_pkg::result_type rsp_result;
   logic                item_valid;
   logic                advance;

   assign req_item.mode        = req_mode;
   assign req_item.pulse_width = req_pulse_width;
   assign req_item.setup_link  = req_setup_link;

   sps_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sps_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (advance),
      .item      (item),
      .result    (result)
   );

   sps_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .advance    (advance),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_relay_on       = rsp_result.relay_on;
   assign rsp_led_on         = rsp_result.led_on;
   assign rsp_no_signal      = rsp_result.no_signal;
   assign rsp_setup_active   = rsp_result.setup_active;
   assign rsp_error_flag     = rsp_result.error_flag;
   assign rsp_midpoint       = rsp_result.midpoint;
   assign rsp_store_midpoint = rsp_result.store_midpoint;
   assign rsp_store_relay    = rsp_result.store_relay;

endmodule

@@ bench/tb_servo_pulse_threshold_switch.sv @@
// ----------------------------------------------------------------------------
// Servo pulse threshold switch testbench
// Drives pulse and poll-tick items through the switch, predicts every result
// item in step with acceptance and compares them in order. Directed tests
// cover the register windows, pulse classes, idle timeout and setup capture;
// random phases then mix hysteresis runs, setup sequences, idle bursts and
// noise under changing register settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_servo_pulse_threshold_switch;

   localparam int STALL_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;
   localparam logic [4:0] BLINK_BEATS = 5'd16;

   // DUT signals
   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_pulse_width;
   logic        req_setup_link;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_relay_on;
   logic        rsp_led_on;
   logic        rsp_no_signal;
   logic        rsp_setup_active;
   logic        rsp_error_flag;
   logic [7:0]  rsp_midpoint;
   logic        rsp_store_midpoint;
   logic        rsp_store_relay;

   // Predicted switch state
   logic        relay_q      = 1'b0;
   logic [7:0]  mid_q        = sps_pkg::PW_DEFAULT_MID;
   logic [3:0]  stable_cnt   = '0;
   logic [15:0] idle_cnt     = '0;
   logic        setup_q      = 1'b0;
   logic [2:0]  strap_cnt    = '0;
   logic [7:0]  capture_q    = '0;
   logic        err_q        = 1'b0;
   logic [4:0]  err_hold_cnt = '0;
   logic [2:0]  blink_div    = '0;
   logic [4:0]  beat_q       = '0;
   logic        led_q        = 1'b0;
   logic        nosig_q      = 1'b0;

   // Register mirror
   logic [3:0]  cfg_stability   = sps_pkg::STABILITY_COUNT_RESET;
   logic [15:0] cfg_nosig_ticks = sps_pkg::NO_SIGNAL_TICKS_RESET;
   logic [3:0]  cfg_half_hyst   = sps_pkg::HALF_HYST_RESET;

   sps_pkg::result_type pending_results[$];

   // Handshake idling and bookkeeping
   int send_gap_pct  = 0;
   int recv_gap_pct  = 0;
   int hold_off_left = 0;
   int stall_cycles  = 0;
   int item_count    = 0;
   int result_count  = 0;
   int mismatch_count = 0;
   int settings_count = 0;
   int relay_store_count = 0;
   int mid_store_count   = 0;
   int setup_error_count = 0;
   int nosig_step_count  = 0;

   servo_pulse_threshold_switch dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_pulse_width    (req_pulse_width),
      .req_setup_link     (req_setup_link),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_relay_on       (rsp_relay_on),
      .rsp_led_on         (rsp_led_on),
      .rsp_no_signal      (rsp_no_signal),
      .rsp_setup_active   (rsp_setup_active),
      .rsp_error_flag     (rsp_error_flag),
      .rsp_midpoint       (rsp_midpoint),
      .rsp_store_midpoint (rsp_store_midpoint),
      .rsp_store_relay    (rsp_store_relay)
   );

   // Clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One LED sequencer step
   function automatic void blink_advance(input logic nosig);
      nosig_q = nosig;
      if (nosig)
         nosig_step_count++;
      blink_div = blink_div + 3'd1;
      if (blink_div <= sps_pkg::BLINK_DIV_LIMIT)
         return;
      blink_div = '0;
      beat_q = beat_q + 5'd1;
      if (beat_q == 5'd1)
         led_q = 1'b1;
      else if (beat_q == 5'd4)
         led_q = relay_q | setup_q | err_q;
      else if (beat_q <= 5'd9)
         led_q = setup_q | err_q;
      else if (beat_q < BLINK_BEATS)
         led_q = err_q;
      else begin
         led_q = 1'b0;
         beat_q = '0;
      end
   endfunction

   // Advance the switch state by one item and return its result
   function automatic sps_pkg::result_type predict_switch_step(input sps_pkg::item_type it);
      int   thr;
      int   delta;
      int   mag;
      logic want;
      logic mid_store;
      logic relay_store;
      mid_store = 1'b0;
      relay_store = 1'b0;
      if (it.mode == 1'b0) begin
         if (it.pulse_width > sps_pkg::PW_TOO_LONG) begin
            stable_cnt = '0;
            blink_advance(1'b1);
         end else if (it.pulse_width < sps_pkg::PW_SPIKE) begin
            stable_cnt = '0;
            idle_cnt = '0;
         end else begin
            if (stable_cnt < sps_pkg::STABLE_MAX)
               stable_cnt = stable_cnt + 4'd1;
            if (stable_cnt >= cfg_stability) begin
               // relay decision with hysteresis
               thr = relay_q ? int'(mid_q) - int'(cfg_half_hyst)
                             : int'(mid_q) + int'(cfg_half_hyst);
               want = (int'(it.pulse_width) > thr);
               if (want != relay_q) begin
                  relay_q = want;
                  relay_store = 1'b1;
                  relay_store_count++;
               end
               blink_advance(1'b0);
               // error display hold-down
               if (err_hold_cnt != '0)
                  err_hold_cnt = err_hold_cnt - 5'd1;
               else
                  err_q = 1'b0;
               // setup strap: debounce, capture, then midpoint or too-close error on release
               if (it.setup_link) begin
                  if (strap_cnt < sps_pkg::DEBOUNCE_LIMIT)
                     strap_cnt = strap_cnt + 3'd1;
                  else if (!setup_q) begin
                     capture_q = it.pulse_width;
                     setup_q = 1'b1;
                  end
               end else begin
                  if (setup_q) begin
                     delta = int'(it.pulse_width >> 1) - int'(capture_q >> 1);
                     mag = (delta < 0) ? -delta : delta;
                     if (mag <= int'(sps_pkg::SETUP_MIN_DIFF)) begin
                        err_hold_cnt = sps_pkg::ERROR_HOLD_STEPS;
                        err_q = 1'b1;
                        setup_error_count++;
                     end else begin
                        mid_q = 8'(int'(capture_q) + delta);
                        mid_store = 1'b1;
                        mid_store_count++;
                     end
                  end
                  setup_q = 1'b0;
                  strap_cnt = '0;
               end
            end
            idle_cnt = '0;
         end
      end else begin
         idle_cnt = idle_cnt + 16'd1;
         if (idle_cnt > cfg_nosig_ticks) begin
            blink_advance(1'b1);
            idle_cnt = '0;
         end
      end
      return {relay_q, led_q, nosig_q, setup_q, err_q, mid_q, mid_store, relay_store};
   endfunction

   // Valid pulse width scattered around a center
   function automatic logic [7:0] near_width(input int center, input int spread);
      int w;
      w = center - spread + int'($urandom_range(2 * spread));
      if (w < int'(sps_pkg::PW_SPIKE))
         w = int'(sps_pkg::PW_SPIKE);
      if (w > int'(sps_pkg::PW_TOO_LONG))
         w = int'(sps_pkg::PW_TOO_LONG);
      return 8'(w);
   endfunction

   // Offer one item and record its expected result on acceptance
   task automatic offer_item(input logic mode, input logic [7:0] width, input logic link);
      sps_pkg::item_type it;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      it.mode = mode;
      it.pulse_width = width;
      it.setup_link = link;
      req_valid = 1'b1;
      req_mode = mode;
      req_pulse_width = width;
      req_setup_link = link;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      pending_results.push_back(predict_switch_step(it));
      item_count++;
   endtask

   // Drop valid and wait until every outstanding result is back
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called with the block idle
   task automatic write_csr(input sps_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         sps_pkg::CSR_INITIAL_MIDPOINT: begin
            mid_q = (data[7:0] >= sps_pkg::PW_TOO_LONG || data[7:0] <= sps_pkg::PW_SPIKE)
                  ? sps_pkg::PW_DEFAULT_MID : data[7:0];
         end
         sps_pkg::CSR_INITIAL_RELAY:   relay_q = data[0];
         sps_pkg::CSR_STABILITY_COUNT: cfg_stability = data[3:0];
         sps_pkg::CSR_NO_SIGNAL_TICKS: cfg_nosig_ticks = data;
         sps_pkg::CSR_HALF_HYSTERESIS: cfg_half_hyst = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Full register set; unused upper bits carry junk
   task automatic apply_settings(input logic [7:0] mid, input logic relay,
                                 input logic [3:0] stab, input logic [15:0] ticks,
                                 input logic [3:0] hyst);
      write_csr(sps_pkg::CSR_INITIAL_MIDPOINT, {8'($urandom), mid});
      write_csr(sps_pkg::CSR_INITIAL_RELAY, {15'($urandom), relay});
      write_csr(sps_pkg::CSR_STABILITY_COUNT, {12'($urandom), stab});
      write_csr(sps_pkg::CSR_NO_SIGNAL_TICKS, ticks);
      write_csr(sps_pkg::CSR_HALF_HYSTERESIS, {12'($urandom), hyst});
      settings_count++;
   endtask

   // Mixed traffic, mostly well-formed pulse trains and setup sequences
   task automatic run_mixed_traffic(input int target);
      int first;
      int pick;
      int len;
      logic [7:0] cap;
      first = item_count;
      while (item_count - first < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // pulse train around the midpoint
            len = $urandom_range(20, 3);
            repeat (len)
               offer_item(1'b0, near_width(mid_q, int'(cfg_half_hyst) + 5), 1'b0);
         end else if (pick < 65) begin
            // setup: settle, hold strap through capture, release
            len = (cfg_stability == '0) ? 1 : int'(cfg_stability);
            repeat (len)
               offer_item(1'b0, near_width(mid_q, 8), 1'b0);
            cap = 8'($urandom_range(sps_pkg::PW_TOO_LONG, sps_pkg::PW_SPIKE));
            len = $urandom_range(9, 6);
            repeat (len)
               offer_item(1'b0, cap, 1'b1);
            if ($urandom_range(1))
               offer_item(1'b0, near_width(cap, 10), 1'b0);
            else
               offer_item(1'b0, 8'($urandom_range(sps_pkg::PW_TOO_LONG, sps_pkg::PW_SPIKE)),
                          1'b0);
         end else if (pick < 80) begin
            // idle-low poll ticks
            len = (cfg_nosig_ticks < 16'd60) ? $urandom_range(int'(cfg_nosig_ticks) + 3, 1)
                                             : $urandom_range(12, 1);
            repeat (len)
               offer_item(1'b1, 8'($urandom), 1'($urandom));
         end else if (pick < 90) begin
            // too-long pulses
            len = $urandom_range(3, 1);
            repeat (len)
               offer_item(1'b0, 8'($urandom_range(255, int'(sps_pkg::PW_TOO_LONG) + 1)),
                          1'($urandom));
         end else begin
            // noise
            len = $urandom_range(5, 1);
            repeat (len)
               offer_item(1'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic test_reset_defaults();
      offer_item(1'b1, 8'hFF, 1'b1);
   endtask

   // Start midpoint window edges and relay restore
   task automatic test_start_registers();
      logic [7:0] mids[6];
      mids = '{8'd0, 8'd20, 8'd21, 8'd167, 8'd168, 8'd255};
      for (int i = 0; i < 6; i++) begin
         settle_block();
         write_csr(sps_pkg::CSR_INITIAL_MIDPOINT, {8'hA5, mids[i]});
         write_csr(sps_pkg::CSR_INITIAL_RELAY, {15'h5A5A, 1'(i % 2)});
         offer_item(1'b0, (i % 2) ? 8'd19 : 8'd0, 1'(i % 2));
      end
   endtask

   // Valid range edges, hysteresis at zero, too-long and spike
   task automatic test_pulse_classes();
      settle_block();
      apply_settings(8'd100, 1'b0, 4'd1, sps_pkg::NO_SIGNAL_TICKS_RESET, 4'd0);
      offer_item(1'b0, sps_pkg::PW_SPIKE, 1'b0);
      offer_item(1'b0, sps_pkg::PW_TOO_LONG, 1'b0);
      offer_item(1'b0, 8'd101, 1'b0);
      offer_item(1'b0, 8'd100, 1'b0);
      offer_item(1'b0, sps_pkg::PW_TOO_LONG + 8'd1, 1'b1);
      offer_item(1'b0, sps_pkg::PW_SPIKE - 8'd1, 1'b1);
   endtask

   // Idle timeout at a setting of one and at the value that never fires
   task automatic test_idle_timeout();
      settle_block();
      write_csr(sps_pkg::CSR_NO_SIGNAL_TICKS, 16'd1);
      offer_item(1'b1, 8'd0, 1'b0);
      offer_item(1'b1, 8'd255, 1'b1);
      settle_block();
      write_csr(sps_pkg::CSR_NO_SIGNAL_TICKS, 16'hFFFF);
      offer_item(1'b1, 8'd85, 1'b0);
      offer_item(1'b1, 8'd170, 1'b1);
   endtask

   // One capture giving a new midpoint, one giving the too-close error
   task automatic test_setup_capture();
      settle_block();
      apply_settings(sps_pkg::PW_DEFAULT_MID, 1'b0, 4'd1, sps_pkg::NO_SIGNAL_TICKS_RESET, 4'd2);
      repeat (6) offer_item(1'b0, 8'd40, 1'b1);
      offer_item(1'b0, 8'd140, 1'b0);
      repeat (6) offer_item(1'b0, 8'd100, 1'b1);
      offer_item(1'b0, 8'd104, 1'b0);
   endtask

   // Three register settings per stage, extremes first
   task automatic test_random_stage(input int stage, input int send_pct, input int recv_pct);
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      for (int phase = 0; phase < 3; phase++) begin
         settle_block();
         case (phase)
            0: apply_settings(8'd21, 1'b1, (stage == 1) ? 4'd0 : 4'd1, 16'd1, 4'd0);
            1: apply_settings(8'd167, 1'b0, 4'd15, 16'hFFFF, 4'd15);
            default: apply_settings(8'($urandom), 1'($urandom), 4'($urandom_range(15, 1)),
                                    16'($urandom_range(60, 1)), 4'($urandom));
         endcase
         run_mixed_traffic(200);
      end
   endtask

   // Long valid run so the stable counter must hold at its top
   task automatic test_stable_saturation();
      settle_block();
      apply_settings(8'd90, 1'b0, 4'd15, 16'd20, 4'd3);
      repeat (20) offer_item(1'b0, near_width(mid_q, 8), 1'b0);
   endtask

   // Receiver holds off while the sender keeps offering
   task automatic test_output_backpressure();
      settle_block();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      hold_off_left = 64;
      run_mixed_traffic(24);
   endtask

   // Sender stops until the pipeline is empty, then resumes
   task automatic test_sender_pause();
      run_mixed_traffic(20);
      settle_block();
      run_mixed_traffic(20);
   endtask

   // Receiver readiness
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready = 1'b0;
      end else
         rsp_ready = ($urandom_range(99) >= recv_gap_pct);
   end

   // Result checking against the oldest expectation
   always @(posedge clock) begin : check_results
      sps_pkg::result_type seen;
      sps_pkg::result_type wanted;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen = {rsp_relay_on, rsp_led_on, rsp_no_signal, rsp_setup_active,
                 rsp_error_flag, rsp_midpoint, rsp_store_midpoint, rsp_store_relay};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("ERROR: unexpected result item at %0t", $time);
         end else begin
            wanted = pending_results.pop_front();
            result_count++;
            if (seen !== wanted) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("ERROR: result %0d wrong at %0t", result_count, $time);
                  $display({"  expected relay=%b led=%b nosig=%b setup=%b err=%b",
                            " mid=%0d smid=%b srly=%b"},
                           wanted.relay_on, wanted.led_on, wanted.no_signal,
                           wanted.setup_active, wanted.error_flag, wanted.midpoint,
                           wanted.store_midpoint, wanted.store_relay);
                  $display({"  actual   relay=%b led=%b nosig=%b setup=%b err=%b",
                            " mid=%0d smid=%b srly=%b"},
                           seen.relay_on, seen.led_on, seen.no_signal,
                           seen.setup_active, seen.error_flag, seen.midpoint,
                           seen.store_midpoint, seen.store_relay);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Test sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = sps_pkg::CSR_INITIAL_MIDPOINT;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_pulse_width = '0;
      req_setup_link = 1'b0;
      rsp_ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_gap_pct = 27;
      recv_gap_pct = 69;
      test_reset_defaults();
      test_start_registers();
      test_pulse_classes();
      test_idle_timeout();
      test_setup_capture();
      test_random_stage(0, 27, 69);
      test_stable_saturation();
      test_random_stage(1, 69, 27);
      test_random_stage(2, 0, 0);
      test_output_backpressure();
      test_sender_pause();

      settle_block();
      repeat (8) @(posedge clock);
      $display("Covered %0d items, %0d results checked, %0d register settings",
               item_count, result_count, settings_count);
      $display("Saw %0d relay stores, %0d midpoint stores, %0d setup errors, %0d no-signal steps",
               relay_store_count, mid_store_count, setup_error_count, nosig_step_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
